@@ rtl/tmce_pkg.sv @@
package tmce_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Fixed field widths.
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int OFF_W  = 11;
    localparam int CELL_W = 16;
    localparam int SUM_W  = COL_W + ROW_W;

    // Character codes.
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_LAST  = 8'h7E;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;

    // Tab stop spacing and the mask that aligns to it.
    localparam logic [7:0] TAB_STEP = 8'd4;
    localparam logic [7:0] TAB_MASK = ~8'd3;

    // Attribute used for blanks after reset.
    localparam logic [7:0] TEXT_COLOR_RST = 8'd15;

    // Operation codes.
    localparam logic [2:0] OP_PUT   = 3'd0;
    localparam logic [2:0] OP_ERASE = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_SETC  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_BLANK,
        ST_READ_WAIT,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_FILL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] char_code;
        logic [7:0] char_color;
        logic [7:0] target_col;
        logic [7:0] target_row;
    } t_cmd;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [OFF_W-1:0]  cursor_offset;
        logic [CELL_W-1:0] cell_value;
        logic              out_of_range;
    } t_result;

endpackage

@@ rtl/tmce_screen_ram.sv @@
module tmce_screen_ram #(
    parameter int DEPTH = tmce_pkg::COLUMNS_DEF * tmce_pkg::ROWS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tmce_pkg::CELL_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [tmce_pkg::CELL_W-1:0] o_rdata
);

    logic [tmce_pkg::CELL_W-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ rtl/text_mode_console_engine_core.sv @@
// Text console over a COLUMNS x ROWS screen store. A command is taken when start is high
// and busy is low; its single result appears on o_result for exactly one cycle with o_done
// high and cannot be held off, so the receiver must take it then. Put char without a
// scroll, set cursor, an off-screen read and the unused ops go from EXEC straight to DONE;
// read cell and an erase that stays on its row pass through READ_WAIT or BLANK first;
// an erase at column 0 adds SRCH_RD and SRCH_CHK per column searched in the row above.
// A put char that scrolls walks the store through the RAM with SCR_RD and SCR_WR
// per copied cell and then FILL per cell of the new bottom row; clear runs FILL over every
// cell. After reset the block stays busy while it fills the store with blanks; the
// configuration port is always ready.
module text_mode_console_engine_core #(
    parameter int COLUMNS = tmce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmce_pkg::ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  tmce_pkg::t_cmd    i_cmd,
    output logic              o_done,
    output tmce_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    localparam int COL_W = tmce_pkg::COL_W;
    localparam int ROW_W = tmce_pkg::ROW_W;
    localparam int SUM_W = tmce_pkg::SUM_W;

    tmce_pkg::t_state r_state, n_state;
    tmce_pkg::t_cmd   r_cmd, n_cmd;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [AW-1:0]    r_addr, n_addr;
    logic [7:0]       r_fill_attr, n_fill_attr;
    logic             r_init, n_init;
    logic [15:0]      r_cell, n_cell;
    logic             r_oor, n_oor;
    logic [7:0]       r_text_color;

    // RAM port signals.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_rdata;

    // Shared address unit: row * COLUMNS + col.
    logic             au_use_target;
    logic [COL_W-1:0] au_col;
    logic [ROW_W-1:0] au_row;
    logic [SUM_W-1:0] au_sum;

    // Put-char cursor arithmetic.
    logic [7:0]       pc_col;
    logic [ROW_W:0]   pc_row;
    logic             pc_print;
    logic             tgt_inside;

    tmce_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Address unit operand selection and multiply-add.
    always_comb begin
        au_col = au_use_target ? r_cmd.target_col[COL_W-1:0] : r_col;
        au_row = au_use_target ? r_cmd.target_row[ROW_W-1:0] : r_row;
        au_sum = SUM_W'({{(SUM_W-ROW_W){1'b0}}, au_row} * SUM_W'(COLUMNS))
               + SUM_W'(au_col);
    end

    assign tgt_inside = (r_cmd.target_col < 8'(COLUMNS)) && (r_cmd.target_row < 8'(ROWS));
    assign pc_print   = (r_cmd.char_code >= tmce_pkg::CH_BLANK)
                     && (r_cmd.char_code <= tmce_pkg::CH_LAST);

    // Cursor update for put char, including wrap at the line end.
    always_comb begin
        pc_col = {1'b0, r_col};
        pc_row = {1'b0, r_row};
        case (r_cmd.char_code)
            tmce_pkg::CH_LF: begin
                pc_col = 8'd0;
                pc_row = pc_row + 1'b1;
            end
            tmce_pkg::CH_TAB: begin
                pc_col = (pc_col + tmce_pkg::TAB_STEP) & tmce_pkg::TAB_MASK;
            end
            tmce_pkg::CH_CR: begin
                pc_col = 8'd0;
            end
            tmce_pkg::CH_BS: begin
                if (r_col != '0) begin
                    pc_col = pc_col - 1'b1;
                end
            end
            default: begin
                if (pc_print) begin
                    pc_col = pc_col + 1'b1;
                end
            end
        endcase
        if (pc_col >= 8'(COLUMNS)) begin
            pc_col = 8'd0;
            pc_row = pc_row + 1'b1;
        end
    end

    // Sequencer: next state, cursor, RAM control.
    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_col         = r_col;
        n_row         = r_row;
        n_addr        = r_addr;
        n_fill_attr   = r_fill_attr;
        n_init        = r_init;
        n_cell        = r_cell;
        n_oor         = r_oor;
        au_use_target = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = au_sum[AW-1:0];
        mem_wdata     = {r_text_color, tmce_pkg::CH_BLANK};
        mem_raddr     = au_sum[AW-1:0];

        unique case (r_state)
            tmce_pkg::ST_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_state = tmce_pkg::ST_EXEC;
                end
            end
            tmce_pkg::ST_EXEC: begin
                n_cell  = '0;
                n_oor   = 1'b0;
                n_state = tmce_pkg::ST_DONE;
                case (r_cmd.op)
                    tmce_pkg::OP_PUT: begin
                        mem_we    = pc_print;
                        mem_wdata = {r_cmd.char_color, r_cmd.char_code};
                        n_col     = pc_col[COL_W-1:0];
                        if (pc_row >= (ROW_W+1)'(ROWS)) begin
                            n_row       = ROW_W'(ROWS - 1);
                            n_addr      = '0;
                            n_fill_attr = r_text_color;
                            n_state     = tmce_pkg::ST_SCR_RD;
                        end else begin
                            n_row = pc_row[ROW_W-1:0];
                        end
                    end
                    tmce_pkg::OP_ERASE: begin
                        if (r_col != '0) begin
                            n_col   = r_col - 1'b1;
                            n_state = tmce_pkg::ST_BLANK;
                        end else if (r_row != '0) begin
                            n_row   = r_row - 1'b1;
                            n_col   = COL_W'(COLUMNS - 1);
                            n_state = tmce_pkg::ST_SRCH_RD;
                        end else begin
                            n_state = tmce_pkg::ST_BLANK;
                        end
                    end
                    tmce_pkg::OP_CLEAR: begin
                        n_col       = '0;
                        n_row       = '0;
                        n_addr      = '0;
                        n_fill_attr = r_text_color;
                        n_state     = tmce_pkg::ST_FILL;
                    end
                    tmce_pkg::OP_SETC: begin
                        if (tgt_inside) begin
                            n_col = r_cmd.target_col[COL_W-1:0];
                            n_row = r_cmd.target_row[ROW_W-1:0];
                        end else begin
                            n_oor = 1'b1;
                        end
                    end
                    tmce_pkg::OP_READ: begin
                        au_use_target = 1'b1;
                        if (tgt_inside) begin
                            n_state = tmce_pkg::ST_READ_WAIT;
                        end else begin
                            n_oor = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            tmce_pkg::ST_SRCH_RD: begin
                // Read the cell under the cursor unless the search hit column 0.
                if (r_col == '0) begin
                    n_state = tmce_pkg::ST_BLANK;
                end else begin
                    n_state = tmce_pkg::ST_SRCH_CHK;
                end
            end
            tmce_pkg::ST_SRCH_CHK: begin
                if (mem_rdata[7:0] == tmce_pkg::CH_BLANK) begin
                    n_col   = r_col - 1'b1;
                    n_state = tmce_pkg::ST_SRCH_RD;
                end else begin
                    n_state = tmce_pkg::ST_BLANK;
                end
            end
            tmce_pkg::ST_BLANK: begin
                mem_we  = 1'b1;
                n_state = tmce_pkg::ST_DONE;
            end
            tmce_pkg::ST_READ_WAIT: begin
                n_cell  = mem_rdata;
                n_state = tmce_pkg::ST_DONE;
            end
            tmce_pkg::ST_SCR_RD: begin
                // Fetch the cell one row below the write pointer.
                mem_raddr = r_addr + AW'(COLUMNS);
                n_state   = tmce_pkg::ST_SCR_WR;
            end
            tmce_pkg::ST_SCR_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = mem_rdata;
                n_addr    = r_addr + 1'b1;
                if (r_addr == AW'(CELLS - COLUMNS - 1)) begin
                    n_state = tmce_pkg::ST_FILL;
                end else begin
                    n_state = tmce_pkg::ST_SCR_RD;
                end
            end
            tmce_pkg::ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = {r_fill_attr, tmce_pkg::CH_BLANK};
                n_addr    = r_addr + 1'b1;
                if (r_addr == AW'(CELLS - 1)) begin
                    n_addr  = '0;
                    n_init  = 1'b0;
                    n_state = r_init ? tmce_pkg::ST_IDLE : tmce_pkg::ST_DONE;
                end
            end
            tmce_pkg::ST_DONE: begin
                n_state = tmce_pkg::ST_IDLE;
            end
            default: begin
                n_state = tmce_pkg::ST_IDLE;
            end
        endcase
    end

    // State and cursor registers; reset starts the blanking pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tmce_pkg::ST_FILL;
            r_col       <= '0;
            r_row       <= '0;
            r_addr      <= '0;
            r_fill_attr <= tmce_pkg::TEXT_COLOR_RST;
            r_init      <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_addr      <= n_addr;
            r_fill_attr <= n_fill_attr;
            r_init      <= n_init;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_cell <= n_cell;
        r_oor  <= n_oor;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= tmce_pkg::TEXT_COLOR_RST;
        end else if (i_cfg_valid) begin
            r_text_color <= i_cfg_data;
        end
    end

    // Outputs.
    assign busy        = (r_state != tmce_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = (r_state == tmce_pkg::ST_DONE);

    always_comb begin
        o_result               = '0;
        o_result.cursor_col    = r_col;
        o_result.cursor_row    = r_row;
        o_result.cursor_offset = au_sum[tmce_pkg::OFF_W-1:0];
        o_result.cell_value    = r_cell;
        o_result.out_of_range  = r_oor;
    end

`ifndef NO_ASSERTIONS
    // The result strobe o_done never stays asserted past its beat.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // The cursor never leaves the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < (COL_W+1)'(COLUMNS)) && ({1'b0, r_row} < (ROW_W+1)'(ROWS)))
        else $error("cursor off screen");

    // An accepted command keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a command");

    // An off-screen request never returns cell contents.
    a_oor_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.out_of_range) |-> (o_result.cell_value == '0))
        else $error("cell value reported with out-of-range flag");
`endif

endmodule

@@ dv/text_console_checker.sv @@
// Watches the command, result and color channels of the console engine, keeps its own
// copy of the screen store and cursor, and compares every result beat with the oldest
// predicted cursor report.
module text_console_checker
    import tmce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  t_cmd       i_cmd,
    input  logic       i_done,
    input  t_result    i_result,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = COLUMNS * ROWS;

    // Mirror of the screen store, the cursor and the blank attribute.
    logic [15:0] screen [CELLS];
    int unsigned cur_col;
    int unsigned cur_row;
    logic [7:0]  blank_color;

    t_result cursor_reports [$];
    int      mismatch_count;
    int      report_backlog;

    assign o_fail_count = mismatch_count;
    assign o_pending    = report_backlog;

    // One line per mismatch, and the count goes up.
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic blank_all();
        for (int i = 0; i < CELLS; i++) begin
            screen[i] = {blank_color, CH_BLANK};
        end
    endtask

    // Shift every row up by one and open a blank bottom row.
    task automatic shift_rows_up();
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen[i] = {blank_color, CH_BLANK};
        end
        cur_row = ROWS - 1;
    endtask

    task automatic print_char(input logic [7:0] ch, input logic [7:0] color);
        case (ch)
            CH_LF: begin
                cur_col = 0;
                cur_row++;
            end
            CH_TAB: cur_col = (cur_col + TAB_STEP) & TAB_MASK;
            CH_CR:  cur_col = 0;
            CH_BS: begin
                if (cur_col > 0) cur_col--;
            end
            default: begin
                if (ch >= CH_BLANK && ch <= CH_LAST) begin
                    screen[cur_row * COLUMNS + cur_col] = {color, ch};
                    cur_col++;
                end
            end
        endcase
        // Line wrap, then scroll once the cursor drops off the bottom.
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS) shift_rows_up();
    endtask

    // Step left; from column 0 climb to the last non-blank cell of the row above.
    task automatic erase_back();
        if (cur_col > 0) begin
            cur_col--;
        end else if (cur_row > 0) begin
            cur_row--;
            cur_col = COLUMNS - 1;
            while (cur_col > 0 && screen[cur_row * COLUMNS + cur_col][7:0] == CH_BLANK) begin
                cur_col--;
            end
        end
        screen[cur_row * COLUMNS + cur_col] = {blank_color, CH_BLANK};
    endtask

    // Applies one command to the mirror and builds the cursor report it should produce.
    task automatic run_console_cmd(input t_cmd cmd, output t_result report);
        logic on_screen;
        on_screen = cmd.target_col < COLUMNS && cmd.target_row < ROWS;
        report = '0;
        case (cmd.op)
            OP_PUT:   print_char(cmd.char_code, cmd.char_color);
            OP_ERASE: erase_back();
            OP_CLEAR: begin
                blank_all();
                cur_col = 0;
                cur_row = 0;
            end
            OP_SETC: begin
                if (on_screen) begin
                    cur_col = cmd.target_col;
                    cur_row = cmd.target_row;
                end else begin
                    report.out_of_range = 1'b1;
                end
            end
            OP_READ: begin
                if (on_screen) begin
                    report.cell_value = screen[cmd.target_row * COLUMNS + cmd.target_col];
                end else begin
                    report.out_of_range = 1'b1;
                end
            end
            default: ;
        endcase
        report.cursor_col    = COL_W'(cur_col);
        report.cursor_row    = ROW_W'(cur_row);
        report.cursor_offset = OFF_W'(cur_row * COLUMNS + cur_col);
    endtask

    // Results are compared before the command of the same edge is predicted.
    always @(posedge i_clk) begin : watch
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            blank_color = TEXT_COLOR_RST;
            blank_all();
            cur_col = 0;
            cur_row = 0;
            cursor_reports.delete();
        end else begin
            if (i_done) begin
                if (cursor_reports.size() == 0) begin
                    report_mismatch("result beat with nothing expected",
                                    16'(i_result.cursor_offset), 16'h0);
                end else begin
                    want = cursor_reports.pop_front();
                    if (i_result.cursor_col !== want.cursor_col)
                        report_mismatch("cursor_col", 16'(i_result.cursor_col),
                                        16'(want.cursor_col));
                    if (i_result.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", 16'(i_result.cursor_row),
                                        16'(want.cursor_row));
                    if (i_result.cursor_offset !== want.cursor_offset)
                        report_mismatch("cursor_offset", 16'(i_result.cursor_offset),
                                        16'(want.cursor_offset));
                    if (i_result.cell_value !== want.cell_value)
                        report_mismatch("cell_value", i_result.cell_value,
                                        want.cell_value);
                    if (i_result.out_of_range !== want.out_of_range)
                        report_mismatch("out_of_range", 16'(i_result.out_of_range),
                                        16'(want.out_of_range));
                end
            end
            if (i_start && !i_busy) begin
                run_console_cmd(i_cmd, fresh);
                cursor_reports.push_back(fresh);
            end
            if (i_cfg_valid && i_cfg_ready) blank_color = i_cfg_data;
        end
        report_backlog = cursor_reports.size();
    end

    initial begin
        mismatch_count = 0;
        report_backlog = 0;
    end

endmodule

@@ dv/testbench.sv @@
// Drives the console engine with a directed opening and several random phases, each at
// its own blank color, and gives the verdict from the checker's mismatch count.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tmce_pkg::*;

    localparam int COLUMNS = COLUMNS_DEF;
    localparam int ROWS    = ROWS_DEF;

    // Ops 5 to 7 are unused by the engine.
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int PHASE_ITEMS = 300;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_cmd       i_cmd;
    logic       o_done;
    t_result    o_result;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    int   fail_count;
    int   pending;
    logic cmd_taken;
    logic cfg_taken;
    bit   steady_feed;

    text_mode_console_engine_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    text_console_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) console_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Even a run made only of scrolls finishes well inside this.
    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    // Handshake outcomes of each edge, read back by the driver at the falling edge.
    always @(posedge i_clk) begin
        cmd_taken <= i_rst_n && start && !busy;
        cfg_taken <= i_rst_n && i_cfg_valid && o_cfg_ready;
    end

    function automatic t_cmd make_cmd(input logic [2:0] op, input logic [7:0] ch,
                                      input logic [7:0] color, input logic [7:0] col,
                                      input logic [7:0] row);
        t_cmd c;
        c.op         = op;
        c.char_code  = ch;
        c.char_color = color;
        c.target_col = col;
        c.target_row = row;
        return c;
    endfunction

    // Printable text above all, with cursor moves; set cursor leans toward the right
    // edge, column 0 and the bottom row so that wraps, scrolls and searches occur.
    function automatic t_cmd random_cmd();
        t_cmd        c;
        int unsigned pick;
        c.op         = OP_PUT;
        c.char_code  = $urandom;
        c.char_color = $urandom;
        c.target_col = $urandom;
        c.target_row = $urandom;
        pick = $urandom_range(0, 999);
        if (pick < 440) begin
            c.char_code = $urandom_range(CH_LAST, CH_BLANK);
        end else if (pick < 490) begin
            c.char_code = CH_LF;
        end else if (pick < 520) begin
            c.char_code = CH_TAB;
        end else if (pick < 535) begin
            c.char_code = CH_CR;
        end else if (pick < 550) begin
            c.char_code = CH_BS;
        end else if (pick < 580) begin
            // Any byte at all, mostly ignored by the engine.
        end else if (pick < 660) begin
            c.op = OP_ERASE;
        end else if (pick < 800) begin
            c.op = OP_SETC;
            if ($urandom_range(0, 9) != 0) begin
                case ($urandom_range(0, 4))
                    0:       c.target_col = 8'd0;
                    1:       c.target_col = 8'($urandom_range(COLUMNS - 1, COLUMNS - 4));
                    default: c.target_col = 8'($urandom_range(0, COLUMNS - 1));
                endcase
                if ($urandom_range(0, 2) == 0) begin
                    c.target_row = 8'(ROWS - 1);
                end else begin
                    c.target_row = 8'($urandom_range(0, ROWS - 1));
                end
            end
        end else if (pick < 985) begin
            c.op = OP_READ;
            if ($urandom_range(0, 9) != 0) begin
                c.target_col = 8'($urandom_range(0, COLUMNS - 1));
                c.target_row = 8'($urandom_range(0, ROWS - 1));
            end
        end else if (pick < 990) begin
            c.op = OP_CLEAR;
        end else begin
            c.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end
        return c;
    endfunction

    // Offers one command after a random gap and returns at the falling edge after the
    // beat is taken; start stays high so a gapless next command follows directly.
    task automatic issue_cmd(input t_cmd c);
        int gap;
        if ($urandom_range(0, 29) == 0) steady_feed = !steady_feed;
        gap = steady_feed ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(negedge i_clk); while (!cmd_taken);
    endtask

    // Stops offering commands and waits for every report to come back.
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_text_color(input logic [7:0] color);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= color;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        repeat (count) issue_cmd(random_cmd());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        steady_feed = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The store is cleared after reset before the first command is taken.
        wait_drained();

        // Directed opening at the reset color.
        issue_cmd(make_cmd(OP_PUT, 8'h41, 8'h00, 8'h00, 8'h00));
        issue_cmd(make_cmd(OP_PUT, CH_LAST, 8'hFF, 8'hFF, 8'hFF));
        issue_cmd(make_cmd(OP_PUT, CH_BLANK, 8'h5A, 8'h00, 8'h00));
        issue_cmd(make_cmd(OP_PUT, 8'h1F, 8'h33, 8'h00, 8'h00));
        issue_cmd(make_cmd(OP_PUT, CH_LAST + 8'd1, 8'h33, 8'h00, 8'h00));
        issue_cmd(make_cmd(OP_PUT, 8'hFF, 8'h33, 8'h00, 8'h00));
        issue_cmd(make_cmd(OP_PUT, CH_TAB, 8'h00, 8'h00, 8'h00));
        issue_cmd(make_cmd(OP_PUT, CH_BS, 8'h00, 8'h00, 8'h00));
        issue_cmd(make_cmd(OP_PUT, CH_CR, 8'h00, 8'h00, 8'h00));
        issue_cmd(make_cmd(OP_PUT, CH_LF, 8'h00, 8'h00, 8'h00));
        // Tab two cells before the line end wraps to the next row.
        issue_cmd(make_cmd(OP_SETC, 8'h00, 8'h00, 8'(COLUMNS - 2), 8'd1));
        issue_cmd(make_cmd(OP_PUT, CH_TAB, 8'h00, 8'h00, 8'h00));
        // Last cell of the screen: a printable wraps and scrolls, then a newline scrolls.
        issue_cmd(make_cmd(OP_SETC, 8'h00, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1)));
        issue_cmd(make_cmd(OP_PUT, 8'h5A, 8'hC3, 8'h00, 8'h00));
        issue_cmd(make_cmd(OP_PUT, CH_LF, 8'h00, 8'h00, 8'h00));
        // Erase from column 0 searches the row above; at the corner it only blanks.
        issue_cmd(make_cmd(OP_SETC, 8'h00, 8'h00, 8'd0, 8'd1));
        issue_cmd(make_cmd(OP_ERASE, 8'h00, 8'h00, 8'h00, 8'h00));
        issue_cmd(make_cmd(OP_SETC, 8'h00, 8'h00, 8'd0, 8'd0));
        issue_cmd(make_cmd(OP_ERASE, 8'h00, 8'h00, 8'h00, 8'h00));
        // Positions just off the screen, the two corners of it and far off it.
        issue_cmd(make_cmd(OP_SETC, 8'h00, 8'h00, 8'(COLUMNS), 8'd0));
        issue_cmd(make_cmd(OP_SETC, 8'h00, 8'h00, 8'd0, 8'(ROWS)));
        issue_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 8'd0, 8'd0));
        issue_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1)));
        issue_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 8'hFF, 8'hFF));
        issue_cmd(make_cmd(OP_SPARE_LO, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        issue_cmd(make_cmd(OP_SPARE_HI, 8'h00, 8'h00, 8'h00, 8'h00));
        issue_cmd(make_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00));

        // Random phases, each with its own blank color, the extremes first.
        write_text_color(8'h00);
        run_random(PHASE_ITEMS);
        write_text_color(8'hFF);
        run_random(PHASE_ITEMS);
        repeat (3) begin
            write_text_color(8'($urandom_range(1, 254)));
            run_random(PHASE_ITEMS);
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/tmce_pkg.sv
rtl/tmce_screen_ram.sv
rtl/text_mode_console_engine_core.sv
dv/text_console_checker.sv
dv/testbench.sv
